// ===== src/pltbl_pkg.sv =====
// Shared types, codes and sizes for the piecewise-linear breakpoint table.
`default_nettype none
package pltbl_pkg;

  // Table depth and the widths that follow from it.
  localparam int MaxPoints = 64;
  localparam int AW        = $clog2(MaxPoints);
  localparam int CW        = $clog2(MaxPoints + 1);

  // Arithmetic widths for the interpolation unit.
  localparam int DW = 33;
  localparam int PW = 2 * DW;
  localparam int NW = $clog2(PW + 1);

  // Operation codes.
  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_REM   = 2'd1;
  localparam logic [1:0] FUNC_CLR   = 2'd2;
  localparam logic [1:0] FUNC_QUERY = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_RANGE = 3'd1;
  localparam logic [2:0] ST_BAD   = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_ZW    = 3'd4;
  localparam logic [2:0] ST_SAT   = 3'd5;

  // Main sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD,
    S_REM_RD,
    S_REM,
    S_Q0,
    S_QSCAN,
    S_MATH,
    S_DONE
  } seq_state_t;

  // Interpolation unit states.
  typedef enum logic [1:0] {
    L_IDLE,
    L_MUL,
    L_DIV,
    L_FIN
  } lerp_state_t;

  // One stored breakpoint.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  // Result handed back by the interpolation unit.
  typedef struct packed {
    logic               done;
    logic               sat;
    logic signed [31:0] y;
  } lerp_res_t;

endpackage
`default_nettype wire

// ===== src/pltbl_lerp.sv =====
// Multi-cycle interpolation unit: shift-add multiply, then restoring divide.
`default_nettype none
module pltbl_lerp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] q,
  input  wire pltbl_pkg::point_t  p0,
  input  wire pltbl_pkg::point_t  p1,
  output pltbl_pkg::lerp_res_t    res
);
  import pltbl_pkg::*;

  lerp_state_t state_r, state_nxt;
  logic [NW-1:0]      step_r;
  logic [DW-1:0]      dq_r, dx_r, mag_r, quot_r, rem_r;
  logic [PW-1:0]      prod_r;
  logic               neg_r;
  logic signed [31:0] y0_r;
  logic signed [31:0] y_out_r;
  logic               sat_r;

  logic signed [DW-1:0] dy;
  logic [DW:0]          trial;
  logic                 fits;
  logic signed [DW:0]   sum;

  assign dy    = DW'(p1.y) - DW'(p0.y);
  assign trial = {rem_r, prod_r[PW-1]};
  assign fits  = trial >= {1'b0, dx_r};
  assign sum   = neg_r ? ((DW+1)'(y0_r) - (DW+1)'({1'b0, quot_r}))
                       : ((DW+1)'(y0_r) + (DW+1)'({1'b0, quot_r}));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      L_IDLE: if (start) state_nxt = L_MUL;
      L_MUL:  if (step_r == NW'(DW - 1)) state_nxt = L_DIV;
      L_DIV:  if (step_r == NW'(PW - 1)) state_nxt = L_FIN;
      L_FIN:  state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath: one product bit or one quotient bit per cycle.
  always_ff @(posedge clk) begin
    case (state_r)
      L_IDLE: begin
        if (start) begin
          dq_r   <= DW'(q) - DW'(p0.x);
          dx_r   <= DW'(p1.x) - DW'(p0.x);
          neg_r  <= dy[DW-1];
          mag_r  <= dy[DW-1] ? DW'(-dy) : DW'(dy);
          y0_r   <= p0.y;
          prod_r <= '0;
          step_r <= '0;
        end
      end
      L_MUL: begin
        prod_r <= (prod_r << 1) + (mag_r[DW-1] ? PW'(dq_r) : PW'(0));
        mag_r  <= mag_r << 1;
        if (step_r == NW'(DW - 1)) begin
          step_r <= '0;
          rem_r  <= '0;
          quot_r <= '0;
        end else begin
          step_r <= step_r + NW'(1);
        end
      end
      L_DIV: begin
        prod_r <= prod_r << 1;
        rem_r  <= fits ? DW'(trial - {1'b0, dx_r}) : trial[DW-1:0];
        quot_r <= {quot_r[DW-2:0], fits};
        step_r <= step_r + NW'(1);
      end
      L_FIN: begin
        // Clamp to the 32-bit signed range.
        if (sum > (DW+1)'(33'sh0_7FFF_FFFF)) begin
          y_out_r <= 32'sh7FFF_FFFF;
          sat_r   <= 1'b1;
        end else if (sum < -(DW+1)'(34'sh0_8000_0000)) begin
          y_out_r <= 32'sh8000_0000;
          sat_r   <= 1'b1;
        end else begin
          y_out_r <= sum[31:0];
          sat_r   <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Done pulses the cycle after the final stage.
  logic done_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= (state_r == L_FIN);
    end
  end

  assign res.done = done_r;
  assign res.sat  = sat_r;
  assign res.y    = y_out_r;

endmodule
`default_nettype wire

// ===== src/piecewise_linear_table_interp.sv =====
// Top level: sorted breakpoint table in a synchronous memory with query interpolation.
// An add shifts larger entries up one at a time, a remove moves later entries down, and a
// clear empties the table at once; a query scans the entries, then the interpolation unit
// multiplies, divides, clamps and hands back. One transaction in flight; the next is accepted
// the cycle after the result is loaded, and a result still waiting holds the sequencer.
// Reset empties the table synchronously; table memory contents are left as they are.
`default_nettype none
module piecewise_linear_table_interp (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // in_tdata: x_value[31:0], y_value[63:32], index[69:64], zero pad [71:70]
  input  wire logic [71:0] in_tdata,
  // in_tuser: func[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_tdata: y_result[31:0], status[34:32], point_count[41:35], zero pad [47:42]
  output logic [47:0]      out_tdata
);
  import pltbl_pkg::*;

  // Breakpoint memory, one read and one write port, registered read.
  point_t mem [MaxPoints];
  point_t rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  point_t        mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  seq_state_t state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      ptr_r, ptr_nxt;
  logic [1:0]         func_r, func_nxt;
  logic signed [31:0] xin_r, xin_nxt, yin_r, yin_nxt;
  point_t             prev_r, prev_nxt;
  logic signed [31:0] res_y_r, res_y_nxt;
  logic [2:0]         res_st_r, res_st_nxt;
  logic               out_valid_r;
  logic [47:0]        out_data_r;
  logic               lerp_start;
  lerp_res_t          lerp_res;

  logic               acc, slot_free;
  logic signed [31:0] in_x, in_y;
  logic [5:0]         in_idx;
  point_t             new_pt;

  assign in_x      = in_tdata[31:0];
  assign in_y      = in_tdata[63:32];
  assign in_idx    = in_tdata[69:64];
  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign new_pt    = '{x: xin_r, y: yin_r};

  pltbl_lerp u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lerp_start),
    .q     (xin_r),
    .p0    (prev_r),
    .p1    (rdata_r),
    .res   (lerp_res)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_tuser)
            FUNC_ADD:   state_nxt = (cnt_r == CW'(MaxPoints)) ? S_DONE : S_ADD_RD;
            FUNC_REM:   state_nxt = (CW'(in_idx) >= cnt_r) ? S_DONE : S_REM_RD;
            FUNC_CLR:   state_nxt = S_DONE;
            FUNC_QUERY: state_nxt = (cnt_r == '0) ? S_DONE : S_Q0;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_ADD_RD: state_nxt = (ptr_r == '0) ? S_DONE : S_ADD;
      S_ADD: begin
        if (rdata_r.x > xin_r) state_nxt = (ptr_r > CW'(1)) ? S_ADD : S_ADD_RD;
        else state_nxt = S_DONE;
      end
      S_REM_RD: state_nxt = (ptr_r + CW'(1) < cnt_r) ? S_REM : S_DONE;
      S_REM:    state_nxt = (ptr_r + CW'(2) < cnt_r) ? S_REM : S_DONE;
      S_Q0: begin
        if (xin_r < rdata_r.x || cnt_r == CW'(1)) state_nxt = S_DONE;
        else state_nxt = S_QSCAN;
      end
      S_QSCAN: begin
        if (xin_r <= rdata_r.x) state_nxt = (rdata_r.x == prev_r.x) ? S_DONE : S_MATH;
        else state_nxt = (ptr_r + CW'(1) < cnt_r) ? S_QSCAN : S_DONE;
      end
      S_MATH:  if (lerp_res.done) state_nxt = S_DONE;
      S_DONE:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    cnt_nxt    = cnt_r;
    ptr_nxt    = ptr_r;
    func_nxt   = func_r;
    xin_nxt    = xin_r;
    yin_nxt    = yin_r;
    prev_nxt   = prev_r;
    res_y_nxt  = res_y_r;
    res_st_nxt = res_st_r;
    mem_we     = 1'b0;
    mem_waddr  = ptr_r[AW-1:0];
    mem_wdata  = rdata_r;
    mem_raddr  = '0;
    lerp_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          func_nxt   = in_tuser;
          xin_nxt    = in_x;
          yin_nxt    = in_y;
          res_y_nxt  = '0;
          res_st_nxt = ST_OK;
          case (in_tuser)
            FUNC_ADD: begin
              ptr_nxt = cnt_r;
              if (cnt_r == CW'(MaxPoints)) res_st_nxt = ST_FULL;
            end
            FUNC_REM: begin
              ptr_nxt = CW'(in_idx);
              if (CW'(in_idx) >= cnt_r) res_st_nxt = ST_BAD;
            end
            FUNC_CLR: cnt_nxt = '0;
            FUNC_QUERY: if (cnt_r == '0) res_st_nxt = ST_BAD;
            default: ;
          endcase
        end
      end
      S_ADD_RD: begin
        if (ptr_r == '0) begin
          mem_we    = 1'b1;
          mem_wdata = new_pt;
          cnt_nxt   = cnt_r + CW'(1);
        end else begin
          mem_raddr = AW'(ptr_r - CW'(1));
        end
      end
      S_ADD: begin
        mem_we = 1'b1;
        if (rdata_r.x > xin_r) begin
          ptr_nxt = ptr_r - CW'(1);
          if (ptr_r > CW'(1)) mem_raddr = AW'(ptr_r - CW'(2));
        end else begin
          mem_wdata = new_pt;
          cnt_nxt   = cnt_r + CW'(1);
        end
      end
      S_REM_RD: begin
        if (ptr_r + CW'(1) < cnt_r) mem_raddr = AW'(ptr_r + CW'(1));
        else cnt_nxt = cnt_r - CW'(1);
      end
      S_REM: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + CW'(1);
        if (ptr_r + CW'(2) < cnt_r) mem_raddr = AW'(ptr_r + CW'(2));
        else cnt_nxt = cnt_r - CW'(1);
      end
      S_Q0: begin
        if (xin_r < rdata_r.x) begin
          res_st_nxt = ST_RANGE;
        end else if (cnt_r == CW'(1)) begin
          if (xin_r == rdata_r.x) res_y_nxt = rdata_r.y;
          else res_st_nxt = ST_RANGE;
        end else begin
          prev_nxt  = rdata_r;
          ptr_nxt   = CW'(1);
          mem_raddr = AW'(1);
        end
      end
      S_QSCAN: begin
        if (xin_r <= rdata_r.x) begin
          if (rdata_r.x == prev_r.x) res_st_nxt = ST_ZW;
          else lerp_start = 1'b1;
        end else begin
          prev_nxt = rdata_r;
          if (ptr_r + CW'(1) < cnt_r) begin
            mem_raddr = AW'(ptr_r + CW'(1));
            ptr_nxt   = ptr_r + CW'(1);
          end else begin
            res_st_nxt = ST_RANGE;
          end
        end
      end
      S_MATH: begin
        if (lerp_res.done) begin
          res_y_nxt  = lerp_res.y;
          res_st_nxt = lerp_res.sat ? ST_SAT : ST_OK;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_DONE && slot_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    func_r   <= func_nxt;
    xin_r    <= xin_nxt;
    yin_r    <= yin_nxt;
    prev_r   <= prev_nxt;
    res_y_r  <= res_y_nxt;
    res_st_r <= res_st_nxt;
    if (state_r == S_DONE && slot_free) begin
      out_data_r <= {6'd0, cnt_r, res_st_r, res_y_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the piecewise-linear breakpoint table with interpolation.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import pltbl_pkg::*;

  // One request to the table and one response from it.
  typedef struct {
    logic [1:0]         func;
    logic signed [31:0] xv;
    logic signed [31:0] yv;
    logic [5:0]         idx;
  } req_t;

  typedef struct {
    logic signed [31:0] y;
    logic [2:0]         st;
    logic [6:0]         cnt;
  } rsp_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors;
  int   accepted;
  int   received;
  bit   calm;
  bit   stim_done;
  int   n_query_ok;
  int   n_full;

  // Predictor's own copy of the table.
  logic signed [31:0] bp_x[MaxPoints];
  logic signed [31:0] bp_y[MaxPoints];
  int                 bp_count;

  piecewise_linear_table_interp DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Interpolate on segment (i-1, i) for query q.
  function automatic rsp_t interp_segment(int i, logic signed [31:0] q);
    rsp_t r;
    longint x0, x1, y0, y1, dy, quot, v;
    longint unsigned udq, udx, umag;
    x0 = bp_x[i - 1];
    x1 = bp_x[i];
    y0 = bp_y[i - 1];
    y1 = bp_y[i];
    r.y = '0;
    r.st = ST_OK;
    r.cnt = bp_count[6:0];
    if (x1 == x0) begin
      r.st = ST_ZW;
      return r;
    end
    dy = y1 - y0;
    // The product can reach nearly 2**64, so it is formed unsigned.
    udq = q - x0;
    udx = x1 - x0;
    umag = dy < 0 ? -dy : dy;
    quot = longint'((udq * umag) / udx);
    v = dy < 0 ? y0 - quot : y0 + quot;
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
      r.st = ST_SAT;
    end
    if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
      r.st = ST_SAT;
    end
    r.y = v[31:0];
    return r;
  endfunction

  // Apply one request to the predicted table and return the expected response.
  function automatic rsp_t table_apply(req_t t);
    rsp_t r;
    int   pos;
    bit   found;
    r.y = '0;
    r.st = ST_OK;
    found = 1'b0;
    case (t.func)
      FUNC_ADD: begin
        if (bp_count >= MaxPoints) begin
          r.st = ST_FULL;
          n_full++;
        end else begin
          pos = 0;
          while (pos < bp_count && bp_x[pos] <= t.xv) pos++;
          for (int i = bp_count; i > pos; i--) begin
            bp_x[i] = bp_x[i - 1];
            bp_y[i] = bp_y[i - 1];
          end
          bp_x[pos] = t.xv;
          bp_y[pos] = t.yv;
          bp_count++;
        end
      end
      FUNC_REM: begin
        if (t.idx >= bp_count) begin
          r.st = ST_BAD;
        end else begin
          for (int i = t.idx; i + 1 < bp_count; i++) begin
            bp_x[i] = bp_x[i + 1];
            bp_y[i] = bp_y[i + 1];
          end
          bp_count--;
        end
      end
      FUNC_CLR: bp_count = 0;
      default: begin
        if (bp_count == 0) r.st = ST_BAD;
        else if (t.xv < bp_x[0]) r.st = ST_RANGE;
        else if (bp_count == 1) begin
          if (t.xv == bp_x[0]) r.y = bp_y[0];
          else r.st = ST_RANGE;
        end else begin
          for (int i = 1; i < bp_count && !found; i++) begin
            if (t.xv <= bp_x[i]) begin
              found = 1'b1;
              r = interp_segment(i, t.xv);
            end
          end
          if (!found) r.st = ST_RANGE;
        end
        if (r.st == ST_OK) n_query_ok++;
      end
    endcase
    r.cnt = bp_count[6:0];
    return r;
  endfunction

  function automatic req_t mk(logic [1:0] f, logic signed [31:0] x,
                              logic signed [31:0] y, logic [5:0] ix);
    req_t t;
    t.func = f;
    t.xv = x;
    t.yv = y;
    t.idx = ix;
    return t;
  endfunction

  // Mostly a narrow x window so that queries land inside the table.
  function automatic logic signed [31:0] rand_x();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $signed($urandom_range(0, 2000)) - 1000;
    if (sel < 8) return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
    return $urandom;
  endfunction

  function automatic logic signed [31:0] rand_y();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed($urandom_range(0, 20000)) - 10000;
  endfunction

  // Stimulus: directed corner cases, then random table traffic.
  initial begin
    int roll;
    int fill;
    for (int i = 0; i < MaxPoints; i++) begin
      bp_x[i] = '0;
      bp_y[i] = '0;
    end
    bp_count = 0;
    // Empty table query and remove.
    pending_reqs.push_back(mk(FUNC_QUERY, 0, 0, 6'd0));
    pending_reqs.push_back(mk(FUNC_REM, 0, 0, 6'd0));
    // Single entry: exact hit and miss on both sides.
    pending_reqs.push_back(mk(FUNC_ADD, 32'sh0001_0000, 32'sh7fff_ffff, 6'd0));
    pending_reqs.push_back(mk(FUNC_QUERY, 32'sh0001_0000, 0, 6'd0));
    pending_reqs.push_back(mk(FUNC_QUERY, 32'sh0000_ffff, 0, 6'd0));
    pending_reqs.push_back(mk(FUNC_QUERY, 32'sh0001_0001, 0, 6'd0));
    // Extreme segment, full swing in y.
    pending_reqs.push_back(mk(FUNC_ADD, 32'sh8000_0000, 32'sh8000_0000, 6'd0));
    pending_reqs.push_back(mk(FUNC_ADD, 32'sh7fff_ffff, 32'sh7fff_ffff, 6'd0));
    pending_reqs.push_back(mk(FUNC_QUERY, 32'sh8000_0000, 0, 6'd0));
    pending_reqs.push_back(mk(FUNC_QUERY, 32'sh7fff_ffff, 0, 6'd0));
    pending_reqs.push_back(mk(FUNC_QUERY, 0, 0, 6'd0));
    pending_reqs.push_back(mk(FUNC_QUERY, 32'shc000_1234, 0, 6'd0));
    // Duplicate x gives a zero-width segment.
    pending_reqs.push_back(mk(FUNC_ADD, 32'sh8000_0000, 32'sh1234_5678, 6'd0));
    pending_reqs.push_back(mk(FUNC_QUERY, 32'sh8000_0000, 0, 6'd0));
    pending_reqs.push_back(mk(FUNC_REM, 0, 0, 6'd63));
    pending_reqs.push_back(mk(FUNC_REM, 0, 0, 6'd1));
    pending_reqs.push_back(mk(FUNC_CLR, 0, 0, 6'd0));
    // Fill to the top and add to a full table.
    for (int i = 0; i < MaxPoints; i++)
      pending_reqs.push_back(mk(FUNC_ADD, rand_x(), rand_y(), 6'd0));
    pending_reqs.push_back(mk(FUNC_ADD, 5, 5, 6'd0));
    pending_reqs.push_back(mk(FUNC_QUERY, 3, 0, 6'd0));
    pending_reqs.push_back(mk(FUNC_REM, 0, 0, 6'd63));
    pending_reqs.push_back(mk(FUNC_CLR, 0, 0, 6'd0));
    // Random traffic: adds and queries dominate, occasional refills and clears.
    for (int n = 0; n < 600; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 35)
        pending_reqs.push_back(mk(FUNC_ADD, rand_x(), rand_y(), 6'($urandom)));
      else if (roll < 45)
        pending_reqs.push_back(mk(FUNC_REM, $urandom, $urandom, 6'($urandom_range(0, 63))));
      else if (roll < 47)
        pending_reqs.push_back(mk(FUNC_CLR, $urandom, $urandom, 6'($urandom)));
      else if (roll < 48) begin
        fill = $urandom_range(50, 66);
        for (int k = 0; k < fill; k++)
          pending_reqs.push_back(mk(FUNC_ADD, rand_x(), rand_y(), 6'($urandom)));
      end else pending_reqs.push_back(mk(FUNC_QUERY, rand_x(), $urandom, 6'($urandom)));
    end
  end

  // Driver: presents queued requests with random gaps.
  always @(posedge clk) begin
    req_t t;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_rsps.push_back(table_apply(pending_reqs.pop_front()));
        accepted++;
      end
      if ((!in_tvalid || in_tready) || !in_tvalid) begin
        if (in_tvalid && !in_tready) begin
          // Hold the current transaction.
        end else if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 32)) begin
          t = pending_reqs[0];
          in_tvalid <= 1'b1;
          in_tdata  <= {2'b00, t.idx, t.yv, t.xv};
          in_tuser  <= t.func;
        end else begin
          in_tvalid <= 1'b0;
          if (pending_reqs.size() == 0) stim_done <= 1'b1;
        end
      end
    end
  end

  // Monitor: random back-pressure and field-by-field comparison.
  always @(posedge clk) begin
    rsp_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        received++;
        if (expected_rsps.size() == 0) begin
          $error("unexpected result transaction: %h", out_tdata);
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (out_tdata[31:0] !== e.y) begin
            $error("y_result: expected %0d, got %0d", e.y, $signed(out_tdata[31:0]));
            errors++;
          end
          if (out_tdata[34:32] !== e.st) begin
            $error("status: expected %0d, got %0d", e.st, out_tdata[34:32]);
            errors++;
          end
          if (out_tdata[41:35] !== e.cnt) begin
            $error("point_count: expected %0d, got %0d", e.cnt, out_tdata[41:35]);
            errors++;
          end
        end
      end
      out_tready <= calm || ($urandom_range(0, 99) >= 32);
    end
  end

  // Reset, a calm stretch in the middle, then drain and report.
  initial begin
    errors = 0;
    accepted = 0;
    received = 0;
    n_query_ok = 0;
    n_full = 0;
    calm = 1'b0;
    stim_done = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (accepted >= 400);
    calm = 1'b1;
    wait (accepted >= 600);
    calm = 1'b0;
    wait (stim_done && pending_reqs.size() == 0 && expected_rsps.size() == 0);
    repeat (300) @(posedge clk);
    $display("Ran %0d transactions: %0d interpolated queries, %0d adds to a full table.",
             received, n_query_ok, n_full);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #40ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
`default_nettype wire

// ===== piecewise_linear_table_interp.f =====
src/pltbl_pkg.sv
src/pltbl_lerp.sv
src/piecewise_linear_table_interp.sv
tb/tb_top.sv
